// File: design/top4_bone_weight_accumulator_core_defines.svh
// Assertion macros for the top-four bone weight accumulator.
// Taken in by the RTL files that carry assertions; depends on nothing.
`ifndef TOP4_BONE_WEIGHT_ACCUMULATOR_CORE_DEFINES_SVH
`define TOP4_BONE_WEIGHT_ACCUMULATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define TBWA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TBWA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/tbwa_pkg.sv
// Shared types and constants of the top-four bone weight accumulator.
// No dependencies; the interfaces and the top level refer to it by scoped names.
`default_nettype none

package tbwa_pkg;

  // Sizes fixed by the item format
  localparam int VERTEX_DEPTH_DEF = 4096;
  localparam int SLOTS            = 4;
  localparam int BYTE_W           = 8;
  localparam int VERTEX_W         = 16;
  localparam int BONE_W           = 8;
  localparam int WEIGHT_W         = 18;
  localparam int STATUS_W         = 2;
  localparam int VCOUNT_W         = 13;
  localparam int WORD_W           = SLOTS * BYTE_W;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RST = 13'd4096;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_FILLED    = 2'd0,
    STAT_REPLACED  = 2'd1,
    STAT_DISCARDED = 2'd2,
    STAT_OUT_RANGE = 2'd3
  } status_t;

  // Controller states: table clearing after reset, then normal running
  typedef enum logic {
    ST_CLEAR = 1'b0,
    ST_RUN   = 1'b1
  } state_t;

  // Four bytes of one vertex entry, slot 0 in the low byte
  typedef logic [SLOTS-1:0][BYTE_W-1:0] slot_bytes_t;

endpackage

`default_nettype wire

// File: design/tbwa_in_if.sv
// Influence request channel: valid/ready handshake with vertex, bone and weight.
// Depends on tbwa_pkg for field widths.
`default_nettype none

interface tbwa_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [tbwa_pkg::VERTEX_W-1:0]        vertex_index;
  logic [tbwa_pkg::BONE_W-1:0]          bone_index;
  logic signed [tbwa_pkg::WEIGHT_W-1:0] weight;

  modport source (output valid, output vertex_index, output bone_index, output weight,
                  input ready);
  modport sink   (input valid, input vertex_index, input bone_index, input weight,
                  output ready);
endinterface

`default_nettype wire

// File: design/tbwa_out_if.sv
// Result channel: valid/ready handshake with status and the four updated slots.
// Depends on tbwa_pkg for field widths.
`default_nettype none

interface tbwa_out_if;
  logic                          valid;
  logic                          ready;
  logic [tbwa_pkg::STATUS_W-1:0] status;
  logic [tbwa_pkg::BONE_W-1:0]   bone_slot0;
  logic [tbwa_pkg::BONE_W-1:0]   bone_slot1;
  logic [tbwa_pkg::BONE_W-1:0]   bone_slot2;
  logic [tbwa_pkg::BONE_W-1:0]   bone_slot3;
  logic [tbwa_pkg::BYTE_W-1:0]   weight_slot0;
  logic [tbwa_pkg::BYTE_W-1:0]   weight_slot1;
  logic [tbwa_pkg::BYTE_W-1:0]   weight_slot2;
  logic [tbwa_pkg::BYTE_W-1:0]   weight_slot3;

  modport source (output valid, output status,
                  output bone_slot0, output bone_slot1, output bone_slot2, output bone_slot3,
                  output weight_slot0, output weight_slot1, output weight_slot2,
                  output weight_slot3,
                  input ready);
  modport sink   (input valid, input status,
                  input bone_slot0, input bone_slot1, input bone_slot2, input bone_slot3,
                  input weight_slot0, input weight_slot1, input weight_slot2,
                  input weight_slot3,
                  output ready);
endinterface

`default_nettype wire

// File: design/tbwa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module tbwa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: design/top4_bone_weight_accumulator_core.sv
// Top level of the top-four bone weight accumulator.
// Depends on tbwa_pkg, tbwa_in_if, tbwa_out_if, tbwa_ram and the defines header.
//
// Usage:
//  - in_chan carries one influence request (vertex, bone, Q2.16 weight); out_chan
//    returns one result per request: a status and the vertex's four slots after
//    the update. Both use valid/ready; a request moves when both are high.
//  - cfg_we/cfg_wdata write vertex_count (reset 4096); write only while idle.
//  - An accepted request is registered in the request stage along with its table read
//    and moves on into the result register, which drives out_chan, once that can take it.
//  - Throughput: one request per cycle while out_chan does not stall. Each request
//    is one read-modify-write of the slot table; a read that meets the entry written
//    on the same edge takes the written word from a forwarding register.
//  - Reset (synchronous, rst_n low) starts a clearing pass that zeroes all
//    VERTEX_DEPTH table entries, one entry per cycle; in_chan.ready stays low meanwhile.
//  - When the receiver stalls, the result register holds, a request in flight holds
//    behind it, and with it in place in_chan.ready drops until out_chan.ready returns.
//  - Vertices at or above vertex_count (or VERTEX_DEPTH) leave the table unchanged
//    and return status 3 with all slots zero.
`default_nettype none
`include "top4_bone_weight_accumulator_core_defines.svh"

module top4_bone_weight_accumulator_core #(
  parameter int VERTEX_DEPTH = tbwa_pkg::VERTEX_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  tbwa_in_if.sink                            in_chan,
  tbwa_out_if.source                         out_chan,
  input  wire logic                          cfg_we,
  input  wire logic [tbwa_pkg::VCOUNT_W-1:0] cfg_wdata
);

  localparam int AW     = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
  localparam int WORD_W = tbwa_pkg::WORD_W;
  localparam int SLOTS  = tbwa_pkg::SLOTS;
  localparam int BYTE_W = tbwa_pkg::BYTE_W;
  localparam int LIM_W  = tbwa_pkg::VERTEX_W + 1;
  localparam logic [LIM_W-1:0] DEPTH_LIM = LIM_W'(VERTEX_DEPTH);
  localparam logic [AW-1:0]    LAST_ADDR = AW'(VERTEX_DEPTH - 1);

  // Controller state and configuration
  tbwa_pkg::state_t                state_r, state_nxt;
  logic [AW-1:0]                   clr_addr_r;
  logic [tbwa_pkg::VCOUNT_W-1:0]   vcount_r;

  // Request stage (waiting on the table read)
  logic                            s1_valid_r;
  logic [AW-1:0]                   s1_addr_r;
  logic [tbwa_pkg::BONE_W-1:0]     s1_bone_r;
  logic [BYTE_W-1:0]               s1_wb_r;
  logic                            s1_in_range_r;
  logic                            s1_adv;

  // Result register
  logic                            out_valid_r;
  tbwa_pkg::status_t               out_status_r;
  tbwa_pkg::slot_bytes_t           out_bone_r;
  tbwa_pkg::slot_bytes_t           out_wt_r;

  // Forwarding of the most recent table write
  logic                            fwd_valid_r;
  logic [AW-1:0]                   fwd_addr_r;
  logic [2*WORD_W-1:0]             fwd_data_r;

  // Table port signals
  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [2*WORD_W-1:0]             ram_wdata;
  logic                            ram_re;
  logic [2*WORD_W-1:0]             ram_rdata;

  // Input side decode
  logic                            in_accept;
  logic                            clearing;
  logic                            in_range;
  logic signed [25:0]              prod;
  logic [9:0]                      prod_int;
  logic [BYTE_W-1:0]               wb_q;

  // Slot update
  tbwa_pkg::slot_bytes_t           cur_bone, cur_wt, new_bone, new_wt;
  tbwa_pkg::status_t               new_status;

  // Table: bone word in the upper half, weight word in the lower half
  tbwa_ram #(
    .WIDTH (2 * WORD_W),
    .DEPTH (VERTEX_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (in_chan.vertex_index[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Next state: clearing pass ends on the last entry
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tbwa_pkg::ST_CLEAR: begin
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = tbwa_pkg::ST_RUN;
        end
      end
      tbwa_pkg::ST_RUN: begin
        state_nxt = tbwa_pkg::ST_RUN;
      end
      default: begin
        state_nxt = tbwa_pkg::ST_CLEAR;
      end
    endcase
  end

  // State outputs
  always_comb begin
    clearing = 1'b0;
    unique case (state_r)
      tbwa_pkg::ST_CLEAR: clearing = 1'b1;
      tbwa_pkg::ST_RUN:   clearing = 1'b0;
      default:            clearing = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= tbwa_pkg::ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (clearing) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= tbwa_pkg::VCOUNT_RST;
    end else if (cfg_we) begin
      vcount_r <= cfg_wdata;
    end
  end

  // Handshake
  assign s1_adv        = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !clearing && (!s1_valid_r || s1_adv);
  assign in_accept     = in_chan.valid && in_chan.ready;
  assign ram_re        = in_accept;

  // Range check against both the register and the table depth
  assign in_range = ({1'b0, in_chan.vertex_index} < DEPTH_LIM) &&
                    ({1'b0, in_chan.vertex_index} < LIM_W'(vcount_r));

  // Weight quantization: w * 255 in Q2.16, truncated, clamped to a byte
  assign prod     = 26'(in_chan.weight) * 26'sd255;
  assign prod_int = prod[25:16];
  always_comb begin
    if (prod <= 26'sd0) begin
      wb_q = '0;
    end else if (prod_int[9:8] != 2'b00) begin
      wb_q = '1;
    end else begin
      wb_q = prod_int[7:0];
    end
  end

  // Request stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_addr_r     <= in_chan.vertex_index[AW-1:0];
      s1_bone_r     <= in_chan.bone_index;
      s1_wb_r       <= wb_q;
      s1_in_range_r <= in_range;
    end
  end

  // Current entry, taking the last write when it hit the same vertex
  always_comb begin
    if (fwd_valid_r && (fwd_addr_r == s1_addr_r)) begin
      cur_bone = fwd_data_r[2*WORD_W-1:WORD_W];
      cur_wt   = fwd_data_r[WORD_W-1:0];
    end else begin
      cur_bone = ram_rdata[2*WORD_W-1:WORD_W];
      cur_wt   = ram_rdata[WORD_W-1:0];
    end
  end

  // Slot choice: first free slot, else replace the lightest if the new one beats it
  always_comb begin
    logic              found;
    logic [1:0]        free_idx;
    logic [1:0]        min_idx;
    logic [BYTE_W-1:0] min_w;
    found    = 1'b0;
    free_idx = '0;
    min_idx  = '0;
    min_w    = cur_wt[0];
    new_bone = cur_bone;
    new_wt   = cur_wt;
    for (int i = 0; i < SLOTS; i++) begin
      if (!found && (cur_wt[i] == '0)) begin
        found    = 1'b1;
        free_idx = 2'(i);
      end
    end
    for (int i = 1; i < SLOTS; i++) begin
      if (cur_wt[i] < min_w) begin
        min_idx = 2'(i);
        min_w   = cur_wt[i];
      end
    end
    priority if (found) begin
      new_bone[free_idx] = s1_bone_r;
      new_wt[free_idx]   = s1_wb_r;
      new_status         = tbwa_pkg::STAT_FILLED;
    end else if (s1_wb_r > min_w) begin
      new_bone[min_idx] = s1_bone_r;
      new_wt[min_idx]   = s1_wb_r;
      new_status        = tbwa_pkg::STAT_REPLACED;
    end else begin
      new_status = tbwa_pkg::STAT_DISCARDED;
    end
  end

  // Table write: zeroes while clearing, else write-back of an advancing in-range request
  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_adv && s1_in_range_r;
      ram_waddr = s1_addr_r;
      ram_wdata = {new_bone, new_wt};
    end
  end

  // Forwarding register follows every write-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else if (ram_we && !clearing) begin
      fwd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we && !clearing) begin
      fwd_addr_r <= ram_waddr;
      fwd_data_r <= ram_wdata;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      if (s1_in_range_r) begin
        out_status_r <= new_status;
        out_bone_r   <= new_bone;
        out_wt_r     <= new_wt;
      end else begin
        out_status_r <= tbwa_pkg::STAT_OUT_RANGE;
        out_bone_r   <= '0;
        out_wt_r     <= '0;
      end
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.bone_slot0   = out_bone_r[0];
  assign out_chan.bone_slot1   = out_bone_r[1];
  assign out_chan.bone_slot2   = out_bone_r[2];
  assign out_chan.bone_slot3   = out_bone_r[3];
  assign out_chan.weight_slot0 = out_wt_r[0];
  assign out_chan.weight_slot1 = out_wt_r[1];
  assign out_chan.weight_slot2 = out_wt_r[2];
  assign out_chan.weight_slot3 = out_wt_r[3];

  // Checks
  `TBWA_ASSERT_NOW(a_clear_idle, clk, rst_n, state_r == tbwa_pkg::ST_CLEAR, !s1_valid_r && !out_valid_r, "request in flight during clearing pass")
  `TBWA_ASSERT_NEXT(a_adv_loads, clk, rst_n, s1_adv, out_valid_r, "advanced request did not reach the result register")
  `TBWA_ASSERT_NEXT(a_wb_matches, clk, rst_n, ram_we && !clearing, (out_bone_r == $past(ram_wdata[2*WORD_W-1:WORD_W])) && (out_wt_r == $past(ram_wdata[WORD_W-1:0])), "write-back differs from returned slots")
  `TBWA_ASSERT_NOW(a_oor_zero, clk, rst_n, out_valid_r && (out_status_r == tbwa_pkg::STAT_OUT_RANGE), (out_bone_r == '0) && (out_wt_r == '0), "out-of-range result carries slot data")

endmodule

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for top4_bone_weight_accumulator_core: streams influence requests,
// predicts the four-slot table per vertex and checks every result field by field.
// Depends on tbwa_pkg, tbwa_in_if, tbwa_out_if and the accumulator RTL.
module tb;

  localparam int CYCLE_LIMIT = 250000;
  localparam int HOT_COUNT   = 12;

  // Field types of one request
  typedef logic [tbwa_pkg::VERTEX_W-1:0]        vertex_t;
  typedef logic [tbwa_pkg::BONE_W-1:0]          bone_t;
  typedef logic signed [tbwa_pkg::WEIGHT_W-1:0] weight_t;

  // One result as the block returns it
  typedef struct packed {
    tbwa_pkg::status_t     status;
    tbwa_pkg::slot_bytes_t bones;
    tbwa_pkg::slot_bytes_t weights;
  } slot_result_t;

  // Scoreboard: own copy of the slot tables, queue of expected slot results
  class influence_tracker;
    tbwa_pkg::slot_bytes_t bone_tab [tbwa_pkg::VERTEX_DEPTH_DEF];
    tbwa_pkg::slot_bytes_t weight_tab [tbwa_pkg::VERTEX_DEPTH_DEF];
    int unsigned  vertex_count;
    slot_result_t expected_slots [$];
    int unsigned  errors;
    int unsigned  results_checked;
    int unsigned  status_seen [4];

    function new();
      foreach (bone_tab[i]) begin
        bone_tab[i]   = '0;
        weight_tab[i] = '0;
      end
      vertex_count    = tbwa_pkg::VCOUNT_RST;
      errors          = 0;
      results_checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // Q2.16 weight times 255, truncated and clamped to a byte
    function logic [7:0] quantise(weight_t w);
      int p;
      p = int'(w) * 255;
      if (p <= 0) return 8'd0;
      p = p >>> 16;
      return (p > 255) ? 8'd255 : p[7:0];
    endfunction

    function slot_result_t predict_slots(vertex_t v, bone_t b, weight_t w);
      slot_result_t r;
      logic [7:0]   q;
      logic [7:0]   min_w;
      int           limit;
      int           min_i;
      bit           placed;
      q     = quantise(w);
      limit = (vertex_count > tbwa_pkg::VERTEX_DEPTH_DEF) ? tbwa_pkg::VERTEX_DEPTH_DEF
                                                          : vertex_count;
      r     = '0;
      if (int'(v) >= limit) begin
        r.status = tbwa_pkg::STAT_OUT_RANGE;
        return r;
      end
      r.bones   = bone_tab[v];
      r.weights = weight_tab[v];
      r.status  = tbwa_pkg::STAT_DISCARDED;
      placed    = 1'b0;
      // first slot with a zero weight byte counts as free
      for (int i = 0; i < tbwa_pkg::SLOTS; i++) begin
        if (!placed && r.weights[i] == 8'd0) begin
          r.bones[i]   = b;
          r.weights[i] = q;
          r.status     = tbwa_pkg::STAT_FILLED;
          placed       = 1'b1;
        end
      end
      // full: lowest weight loses, lowest index on ties, strictly greater only
      if (!placed) begin
        min_i = 0;
        min_w = r.weights[0];
        for (int i = 1; i < tbwa_pkg::SLOTS; i++) begin
          if (r.weights[i] < min_w) begin
            min_i = i;
            min_w = r.weights[i];
          end
        end
        if (q > min_w) begin
          r.bones[min_i]   = b;
          r.weights[min_i] = q;
          r.status         = tbwa_pkg::STAT_REPLACED;
        end
      end
      bone_tab[v]   = r.bones;
      weight_tab[v] = r.weights;
      return r;
    endfunction

    function void note_influence(vertex_t v, bone_t b, weight_t w);
      expected_slots = {expected_slots, predict_slots(v, b, w)};
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH: %s", msg);
    endtask

    task check_result(slot_result_t got);
      slot_result_t want;
      if (expected_slots.size() == 0) begin
        report_mismatch($sformatf("result with no request pending, status %0d", got.status));
        return;
      end
      want = expected_slots.pop_front();
      results_checked++;
      status_seen[want.status]++;
      if (got.status !== want.status)
        report_mismatch($sformatf("result %0d status %0d, want %0d",
                                  results_checked, got.status, want.status));
      for (int i = 0; i < tbwa_pkg::SLOTS; i++) begin
        if (got.bones[i] !== want.bones[i])
          report_mismatch($sformatf("result %0d bone_slot%0d %0d, want %0d",
                                    results_checked, i, got.bones[i], want.bones[i]));
        if (got.weights[i] !== want.weights[i])
          report_mismatch($sformatf("result %0d weight_slot%0d %0d, want %0d",
                                    results_checked, i, got.weights[i], want.weights[i]));
      end
    endtask

    function int pending();
      return expected_slots.size();
    endfunction
  endclass

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          cfg_we    = 1'b0;
  logic [tbwa_pkg::VCOUNT_W-1:0] cfg_wdata = '0;

  tbwa_in_if  in_chan ();
  tbwa_out_if out_chan ();

  top4_bone_weight_accumulator_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  influence_tracker tracker = new();

  int unsigned     cycle_count    = 0;
  int unsigned     burst_left     = 0;
  int unsigned     settings_used  = 0;
  int unsigned     hot_vertex [HOT_COUNT];
  vertex_t         last_vertex = '0;
  slot_result_t    observed;

  always #5 clk = ~clk;

  // Known values on every input from time zero
  initial begin
    in_chan.valid        = 1'b0;
    in_chan.vertex_index = '0;
    in_chan.bone_index   = '0;
    in_chan.weight       = '0;
    out_chan.ready       = 1'b0;
  end

  // Run-away guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: stall pattern switches between modes, including no stalls at all
  int unsigned stall_mode = 0;
  int unsigned mode_left  = 0;
  int unsigned stall_tick = 0;
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 200);
    end
    mode_left--;
    stall_tick++;
    case (stall_mode)
      0: out_chan.ready = 1'b1;
      1: out_chan.ready = ($urandom_range(0, 3) != 0);
      2: out_chan.ready = 1'($urandom_range(0, 1));
      default: out_chan.ready = ((stall_tick % 8) >= 3);
    endcase
  end

  // Monitor: requests and results taken at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready)
        tracker.note_influence(in_chan.vertex_index, in_chan.bone_index, in_chan.weight);
      if (out_chan.valid && out_chan.ready) begin
        observed.status     = tbwa_pkg::status_t'(out_chan.status);
        observed.bones[0]   = out_chan.bone_slot0;
        observed.bones[1]   = out_chan.bone_slot1;
        observed.bones[2]   = out_chan.bone_slot2;
        observed.bones[3]   = out_chan.bone_slot3;
        observed.weights[0] = out_chan.weight_slot0;
        observed.weights[1] = out_chan.weight_slot1;
        observed.weights[2] = out_chan.weight_slot2;
        observed.weights[3] = out_chan.weight_slot3;
        tracker.check_result(observed);
      end
    end
  end

  // Smallest Q2.16 weight that quantises to the given byte
  function automatic weight_t weight_for_byte(int unsigned q);
    return weight_t'((q * 65536 + 254) / 255);
  endfunction

  // Present one request and hold it until the block takes it
  task automatic send_influence(input vertex_t v, input bone_t b, input weight_t w);
    @(negedge clk);
    in_chan.valid        = 1'b1;
    in_chan.vertex_index = v;
    in_chan.bone_index   = b;
    in_chan.weight       = w;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // Sender bursts with random gaps, a third of bursts run straight on
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_chan.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  // Hold off until every result is back
  task automatic drain();
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_vertex_count(input int unsigned count);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = count[tbwa_pkg::VCOUNT_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    tracker.vertex_count = count[tbwa_pkg::VCOUNT_W-1:0];
    settings_used++;
  endtask

  // Directed: weight extremes, zero bytes into free slots, ties, discards, range edges
  task automatic directed_requests();
    // vertex 0: zero-byte weights keep slot 0 free, then it fills
    send_influence(16'd0, 8'd0, 18'sh20000);
    send_influence(16'd0, 8'd255, 18'sh1FFFF);
    send_influence(16'd0, 8'd1, 18'sd1);
    send_influence(16'd0, 8'd2, 18'sd257);
    send_influence(16'd0, 8'd3, 18'sd258);
    send_influence(16'd0, 8'd4, 18'sd65535);
    send_influence(16'd0, 8'd5, 18'sd65536);
    // vertex 0 full: negative, zero and equal bytes are discarded, then a larger byte replaces the lightest
    send_influence(16'd0, 8'd6, -18'sd1);
    send_influence(16'd0, 8'd7, 18'sd0);
    send_influence(16'd0, 8'd8, 18'sd258);
    send_influence(16'd0, 8'd9, weight_for_byte(2));
    // last vertex: equal weights, replacement takes the lowest index
    send_influence(16'd4095, 8'hAA, weight_for_byte(100));
    send_influence(16'd4095, 8'h55, weight_for_byte(100));
    send_influence(16'd4095, 8'h0F, weight_for_byte(100));
    send_influence(16'd4095, 8'hF0, weight_for_byte(100));
    send_influence(16'd4095, 8'h11, weight_for_byte(101));
    send_influence(16'd4095, 8'h22, weight_for_byte(120));
    // out of range
    send_influence(16'd4096, 8'h33, weight_for_byte(200));
    send_influence(16'hFFFF, 8'hFF, 18'sh1FFFF);
    send_influence(16'h8000, 8'h44, weight_for_byte(50));
    // back-to-back on one vertex
    send_influence(16'd4095, 8'h66, weight_for_byte(50));
    send_influence(16'd4095, 8'h77, weight_for_byte(200));
    send_influence(16'd4095, 8'h88, weight_for_byte(200));
  endtask

  task automatic random_influence();
    int unsigned limit;
    int unsigned sel;
    vertex_t     v;
    bone_t       b;
    weight_t     w;
    limit = (tracker.vertex_count > tbwa_pkg::VERTEX_DEPTH_DEF) ? tbwa_pkg::VERTEX_DEPTH_DEF
                                                                : tracker.vertex_count;
    // mostly a few hot vertices so slots fill up and get contested
    sel = $urandom_range(0, 99);
    if (sel < 20)
      v = last_vertex;
    else if (sel < 70)
      v = (limit == 0) ? vertex_t'(hot_vertex[$urandom_range(0, HOT_COUNT - 1)])
                       : vertex_t'(hot_vertex[$urandom_range(0, HOT_COUNT - 1)] % limit);
    else if (sel < 82)
      v = vertex_t'($urandom_range(0, tbwa_pkg::VERTEX_DEPTH_DEF - 1));
    else if (sel < 88)
      v = vertex_t'($urandom_range(tbwa_pkg::VERTEX_DEPTH_DEF - 6,
                                   tbwa_pkg::VERTEX_DEPTH_DEF + 5));
    else
      v = vertex_t'($urandom);
    last_vertex = v;
    b = bone_t'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 35)
      w = weight_for_byte($urandom_range(1, 255));
    else if (sel < 55)
      w = weight_for_byte($urandom_range(1, 24));
    else if (sel < 75)
      w = weight_t'($urandom);
    else if (sel < 82)
      w = weight_t'($urandom_range(0, 257));
    else if (sel < 88)
      w = weight_t'(32'h20000 | $urandom_range(0, 131071));
    else
      w = weight_t'($urandom_range(65536, 131071));
    pace_sender();
    send_influence(v, b, w);
  endtask

  task automatic random_phase(input int unsigned count);
    hot_vertex[0] = 0;
    hot_vertex[1] = tbwa_pkg::VERTEX_DEPTH_DEF - 1;
    for (int i = 2; i < HOT_COUNT; i++)
      hot_vertex[i] = $urandom_range(0, tbwa_pkg::VERTEX_DEPTH_DEF - 1);
    repeat (count) random_influence();
  endtask

  // Sequence: reset, directed, then random phases under several vertex counts
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    directed_requests();
    random_phase(650);
    drain();
    set_vertex_count(8191);
    random_phase(250);
    drain();
    set_vertex_count(0);
    random_phase(40);
    drain();
    set_vertex_count(1);
    random_phase(80);
    drain();
    set_vertex_count($urandom_range(2, 4094));
    random_phase(300);
    drain();
    set_vertex_count(4095);
    random_phase(200);
    drain();
    set_vertex_count(4096);
    random_phase(150);
    drain();

    $display("Checked %0d results over %0d vertex_count settings plus the reset value.",
             tracker.results_checked, settings_used);
    $display("Status mix: %0d filled, %0d replaced, %0d discarded, %0d out of range.",
             tracker.status_seen[tbwa_pkg::STAT_FILLED],
             tracker.status_seen[tbwa_pkg::STAT_REPLACED],
             tracker.status_seen[tbwa_pkg::STAT_DISCARDED],
             tracker.status_seen[tbwa_pkg::STAT_OUT_RANGE]);
    if (tracker.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
